// ===== src/timestamp_ordered_event_queue_macros.svh =====
// assertion macros for the timestamp ordered event queue checker
// expects signals named clk and rst_n in the scope of each use
`ifndef TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIMESTAMP_ORDERED_EVENT_QUEUE_MACROS_SVH

// same-cycle implication, off during reset
`define TOEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TOEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define TOEQ_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/toeq_pkg.sv =====
// shared types and constants of the timestamp ordered event queue
// no dependencies
`default_nettype none

package toeq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 64;
  localparam int TIME_W = 32;
  localparam int DATA_W = 24;

  localparam logic REQ_PUT = 1'b0;
  localparam logic REQ_GET = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_NEG_DELTA = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [TIME_W-1:0] ts;
    logic [DATA_W-1:0] data;
  } entry_t;

endpackage

`default_nettype wire

// ===== src/toeq_if.sv =====
// item channels of the timestamp ordered event queue: input, result, config
// depends on toeq_pkg
`default_nettype none

interface toeq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [toeq_pkg::TIME_W-1:0] msg_time;
  logic [toeq_pkg::DATA_W-1:0] msg_data;
  logic [toeq_pkg::TIME_W-1:0] now_time;

  modport source (output valid, req_type, msg_time, msg_data, now_time, input ready);
  modport sink (input valid, req_type, msg_time, msg_data, now_time, output ready);
endinterface

interface toeq_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        out_valid;
  logic [toeq_pkg::TIME_W-1:0] out_time;
  logic [toeq_pkg::DATA_W-1:0] out_data;
  logic [toeq_pkg::TIME_W-1:0] pulses;

  modport source (output valid, status, out_valid, out_time, out_data, pulses,
                  input ready);
  modport sink (input valid, status, out_valid, out_time, out_data, pulses,
                output ready);
  modport monitor (input valid, ready, status, out_valid, out_time, out_data, pulses);
endinterface

interface toeq_cfg_if;
  logic valid;
  logic ready;
  logic rt_mode;

  modport source (output valid, rt_mode, input ready);
  modport sink (input valid, rt_mode, output ready);
endinterface

`default_nettype wire

// ===== src/toeq_store.sv =====
// entry memory: one write port, one read port with registered read data
// depends on toeq_pkg
`default_nettype none

module toeq_store #(
  parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int AW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire toeq_pkg::entry_t wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output toeq_pkg::entry_t      rdata
);

  toeq_pkg::entry_t mem_r [QUEUE_DEPTH];
  toeq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/toeq_ctrl.sv =====
// sequencer of the event queue: ring pointers, sorted insert by shifting,
// head release, config register and result register; depends on toeq_pkg, toeq_if
`default_nettype none

module toeq_ctrl #(
  parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int AW = $clog2(QUEUE_DEPTH),
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  toeq_in_if.sink               in_ch,
  toeq_out_if.source            out_ch,
  toeq_cfg_if.sink              cfg_ch,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output toeq_pkg::entry_t      mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  wire toeq_pkg::entry_t mem_rdata
);

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_SHIFT, S_PLACE, S_RESP} state_t;

  state_t                      state_r;
  logic [AW-1:0]               head_r;
  logic [CW-1:0]               count_r;
  logic [toeq_pkg::TIME_W-1:0] last_r;
  logic                        rt_r;
  logic [AW-1:0]               cur_p_r;
  logic [toeq_pkg::TIME_W-1:0] req_time_r;
  logic [toeq_pkg::DATA_W-1:0] req_data_r;
  logic [toeq_pkg::TIME_W-1:0] now_r;

  logic [1:0]                  res_status_r;
  logic                        res_valid_r;
  logic [toeq_pkg::TIME_W-1:0] res_time_r;
  logic [toeq_pkg::DATA_W-1:0] res_data_r;
  logic [toeq_pkg::TIME_W-1:0] res_pulses_r;

  logic                        out_v_r;
  logic [1:0]                  out_status_r;
  logic                        out_valid_r;
  logic [toeq_pkg::TIME_W-1:0] out_time_r;
  logic [toeq_pkg::DATA_W-1:0] out_data_r;
  logic [toeq_pkg::TIME_W-1:0] out_pulses_r;

  logic                        accept;
  logic                        out_free;
  logic                        is_empty;
  logic                        is_full;
  logic [AW:0]                 tail_sum;
  logic [AW-1:0]               tail_m1;
  logic                        later;
  logic                        due;
  toeq_pkg::entry_t            new_entry;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - 1'b1;
  endfunction

  assign accept   = in_ch.valid && (state_r == S_IDLE);
  assign out_free = !out_v_r || out_ch.ready;
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));

  // physical slot of the last stored item
  assign tail_sum = {1'b0, head_r} + (AW+1)'(count_r) - (AW+1)'(1);
  assign tail_m1  = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

  assign later     = (mem_rdata.ts > req_time_r);
  assign due       = rt_r || !(mem_rdata.ts > now_r);
  assign new_entry = '{ts: req_time_r, data: req_data_r};

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head_r;
    mem_we    = 1'b0;
    mem_waddr = cur_p_r;
    mem_wdata = new_entry;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !is_empty) begin
          if (in_ch.req_type == toeq_pkg::REQ_GET) begin
            mem_re = 1'b1;
          end else if (!is_full) begin
            mem_re    = 1'b1;
            mem_raddr = tail_m1;
          end
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_inc(cur_p_r);
        if (later) begin
          mem_wdata = mem_rdata;
          if (cur_p_r != head_r) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_dec(cur_p_r);
          end
        end
      end
      S_PLACE: begin
        mem_we = 1'b1;
      end
      S_HEAD, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      last_r  <= '0;
      rt_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        rt_r <= cfg_ch.rt_mode;
      end
      if ((state_r == S_RESP) && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_time_r   <= in_ch.msg_time;
            req_data_r   <= in_ch.msg_data;
            now_r        <= in_ch.now_time;
            res_valid_r  <= 1'b0;
            res_time_r   <= '0;
            res_data_r   <= '0;
            res_pulses_r <= '0;
            if (in_ch.req_type == toeq_pkg::REQ_GET) begin
              if (is_empty) begin
                res_status_r <= toeq_pkg::ST_NOT_READY;
                state_r      <= S_RESP;
              end else begin
                res_status_r <= toeq_pkg::ST_OK;
                state_r      <= S_HEAD;
              end
            end else if (is_full) begin
              res_status_r <= toeq_pkg::ST_FULL;
              state_r      <= S_RESP;
            end else if (is_empty) begin
              res_status_r <= toeq_pkg::ST_OK;
              cur_p_r      <= head_r;
              state_r      <= S_PLACE;
            end else begin
              res_status_r <= toeq_pkg::ST_OK;
              cur_p_r      <= tail_m1;
              state_r      <= S_SHIFT;
            end
          end
        end
        S_HEAD: begin
          if (!due) begin
            res_status_r <= toeq_pkg::ST_NOT_READY;
          end else begin
            head_r  <= ptr_inc(head_r);
            count_r <= count_r - 1'b1;
            if (mem_rdata.ts < last_r) begin
              res_status_r <= toeq_pkg::ST_NEG_DELTA;
            end else begin
              res_valid_r  <= 1'b1;
              res_time_r   <= mem_rdata.ts;
              res_data_r   <= mem_rdata.data;
              res_pulses_r <= mem_rdata.ts - last_r;
              last_r       <= mem_rdata.ts;
            end
          end
          state_r <= S_RESP;
        end
        S_SHIFT: begin
          if (later) begin
            if (cur_p_r == head_r) begin
              state_r <= S_PLACE;
            end else begin
              cur_p_r <= ptr_dec(cur_p_r);
            end
          end else begin
            count_r <= count_r + 1'b1;
            state_r <= S_RESP;
          end
        end
        S_PLACE: begin
          count_r <= count_r + 1'b1;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_valid_r  <= res_valid_r;
            out_time_r   <= res_time_r;
            out_data_r   <= res_data_r;
            out_pulses_r <= res_pulses_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_valid = out_valid_r;
  assign out_ch.out_time  = out_time_r;
  assign out_ch.out_data  = out_data_r;
  assign out_ch.pulses    = out_pulses_r;

endmodule

`default_nettype wire

// ===== src/timestamp_ordered_event_queue.sv =====
// top level of the timestamp ordered event queue
// depends on toeq_pkg, toeq_if, toeq_store, toeq_ctrl
//
// channel  dir  handshake      payload
// in_ch    in   valid/ready    req_type, msg_time, msg_data, now_time
// out_ch   out  valid/ready    status, out_valid, out_time, out_data, pulses
// cfg_ch   in   valid/ready    rt_mode (ready always high)
//
// get: one memory read of the head slot, issued on accept and checked in S_HEAD
// put: the insert walks down from the tail past each stored item with a later
//   timestamp, moving one entry per cycle through the memory's single write port
// full queue or empty get: no memory access; one item in flight at a time
// a result waiting on out_ch stalls only the final step; reset empties the queue
`default_nettype none

module timestamp_ordered_event_queue #(
  parameter int QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input wire logic    clk,
  input wire logic    rst_n,
  toeq_in_if.sink     in_ch,
  toeq_out_if.source  out_ch,
  toeq_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  toeq_pkg::entry_t mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  toeq_pkg::entry_t mem_rdata;

  toeq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  toeq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== src/toeq_checker.sv =====
// port checker of the timestamp ordered event queue, bound to the top level
// depends on toeq_pkg and the macros header
`default_nettype none
`include "timestamp_ordered_event_queue_macros.svh"

module toeq_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        valid,
  input wire logic                        ready,
  input wire logic [1:0]                  status,
  input wire logic                        out_valid,
  input wire logic [toeq_pkg::TIME_W-1:0] out_time,
  input wire logic [toeq_pkg::DATA_W-1:0] out_data,
  input wire logic [toeq_pkg::TIME_W-1:0] pulses
);

  `TOEQ_ASSERT_NEXT(a_out_hold, valid && !ready, valid && $stable(status) && $stable(out_time) && $stable(pulses), "result item changed while stalled")
  `TOEQ_ASSERT_NOW(a_release_ok, valid && out_valid, status == toeq_pkg::ST_OK, "released item without ok status")
  `TOEQ_ASSERT_NOW(a_no_release_zero, valid && !out_valid, out_time == '0 && out_data == '0 && pulses == '0, "fields not zero without release")
  `TOEQ_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !valid, "result valid after reset")

endmodule

bind timestamp_ordered_event_queue toeq_checker u_toeq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .valid     (out_ch.valid),
  .ready     (out_ch.ready),
  .status    (out_ch.status),
  .out_valid (out_ch.out_valid),
  .out_time  (out_ch.out_time),
  .out_data  (out_ch.out_data),
  .pulses    (out_ch.pulses)
);

`default_nettype wire

// ===== sim/timestamp_ordered_event_queue_test.sv =====
// self-checking test of the timestamp ordered event queue: puts, gets, rt_mode, full queue
// keeps its own sorted copy of the queue and compares every result item in order
// depends on toeq_pkg, toeq_if and timestamp_ordered_event_queue
`default_nettype none

module timestamp_ordered_event_queue_test;

  localparam int QUEUE_DEPTH = toeq_pkg::DEFAULT_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [1:0]                  status;
    logic                        released;
    logic [toeq_pkg::TIME_W-1:0] ts;
    logic [toeq_pkg::DATA_W-1:0] data;
    logic [toeq_pkg::TIME_W-1:0] pulses;
  } queue_response_t;

  logic clk;
  logic rst_n;

  toeq_in_if  in_ch();
  toeq_out_if out_ch();
  toeq_cfg_if cfg_ch();

  timestamp_ordered_event_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  toeq_pkg::entry_t            held [QUEUE_DEPTH];
  int                          held_count = 0;
  logic [toeq_pkg::TIME_W-1:0] last_release = '0;
  logic                        rt_mode_shadow = 1'b0;
  queue_response_t             owed_responses [$];

  int                          fail_count = 0;
  int                          cycle_count = 0;
  int                          burst_left = 0;
  int                          hold_requests = 0;
  int                          holds_begun = 0;
  int                          hold_left = 0;
  int                          stretch_left = 0;
  int                          ready_mode = 0;
  logic [toeq_pkg::TIME_W-1:0] time_base = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic queue_response_t apply_request(input logic req,
                                                    input logic [toeq_pkg::TIME_W-1:0] t,
                                                    input logic [toeq_pkg::DATA_W-1:0] d,
                                                    input logic [toeq_pkg::TIME_W-1:0] now);
    queue_response_t  r;
    toeq_pkg::entry_t head;
    int               pos;
    r = '0;
    if (req == toeq_pkg::REQ_PUT) begin
      if (held_count >= QUEUE_DEPTH) begin
        r.status = toeq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos].ts <= t) pos++;
        for (int i = held_count; i > pos; i--) held[i] = held[i-1];
        held[pos].ts = t;
        held[pos].data = d;
        held_count++;
        r.status = toeq_pkg::ST_OK;
      end
    end else if (held_count == 0 || (!rt_mode_shadow && held[0].ts > now)) begin
      r.status = toeq_pkg::ST_NOT_READY;
    end else begin
      head = held[0];
      for (int i = 1; i < held_count; i++) held[i-1] = held[i];
      held_count--;
      if (head.ts < last_release) begin
        r.status = toeq_pkg::ST_NEG_DELTA;
      end else begin
        r.status = toeq_pkg::ST_OK;
        r.released = 1'b1;
        r.ts = head.ts;
        r.data = head.data;
        r.pulses = head.ts - last_release;
        last_release = head.ts;
      end
    end
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    queue_response_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (owed_responses.size() == 0) begin
        $display("%0t: result item with none pending, expected none, actual status %0d",
                 $time, out_ch.status);
        fail_count++;
      end else begin
        want = owed_responses.pop_front();
        report_field("status", 32'(want.status), 32'(out_ch.status));
        report_field("out_valid", 32'(want.released), 32'(out_ch.out_valid));
        report_field("out_time", want.ts, out_ch.out_time);
        report_field("out_data", 32'(want.data), 32'(out_ch.out_data));
        report_field("pulses", want.pulses, out_ch.pulses);
      end
    end
  end

  // result side: long hold on request, otherwise stretches of differing stall patterns
  always @(posedge clk) begin
    if (hold_requests != holds_begun) begin
      holds_begun = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(10, 150);
      ready_mode = $urandom_range(0, 2);
    end else begin
      stretch_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_request(input logic req, input logic [toeq_pkg::TIME_W-1:0] t,
                              input logic [toeq_pkg::DATA_W-1:0] d,
                              input logic [toeq_pkg::TIME_W-1:0] now);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.msg_time <= t;
    in_ch.msg_data <= d;
    in_ch.now_time <= now;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    owed_responses.push_back(apply_request(req, t, d, now));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic put_msg(input logic [toeq_pkg::TIME_W-1:0] t,
                         input logic [toeq_pkg::DATA_W-1:0] d);
    send_request(toeq_pkg::REQ_PUT, t, d, $urandom());
  endtask

  task automatic get_msg(input logic [toeq_pkg::TIME_W-1:0] now);
    send_request(toeq_pkg::REQ_GET, $urandom(), toeq_pkg::DATA_W'($urandom()), now);
  endtask

  task automatic drain_responses();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (owed_responses.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rt_mode(input logic value);
    drain_responses();
    cfg_ch.valid <= 1'b1;
    cfg_ch.rt_mode <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    rt_mode_shadow = value;
  endtask

  task automatic test_ordering();
    get_msg(32'hFFFF_FFFF);
    put_msg(32'd10, 24'h00_90_3C);
    put_msg(32'd3, 24'h7F_40_90);
    put_msg(32'd10, 24'h00_3E_80);
    put_msg(32'd7, 24'h12_34_B0);
    get_msg(32'd2);
    get_msg(32'd3);
    get_msg(32'd0);
    get_msg(32'd10);
    get_msg(32'd10);
    get_msg(32'd10);
    put_msg(32'd4, 24'h55_AA_C0);
    get_msg(32'hFFFF_FFFF);
    get_msg(32'hFFFF_FFFF);
    put_msg(32'd10, 24'hFF_FFFF);
    put_msg(32'd0, 24'h00_0000);
    get_msg(32'd10);
    get_msg(32'd10);
  endtask

  task automatic test_rt_mode();
    write_rt_mode(1'b1);
    put_msg(32'd500, 24'h01_02_03);
    put_msg(32'd20, 24'hA5_5A_F8);
    get_msg(32'd0);
    get_msg(32'd0);
    get_msg(32'd0);
    write_rt_mode(1'b0);
  endtask

  task automatic test_full_queue();
    write_rt_mode(1'b1);
    while (held_count > 0) get_msg($urandom());
    time_base = last_release;
    repeat (QUEUE_DEPTH) begin
      put_msg(time_base + $urandom_range(0, 5000), toeq_pkg::DATA_W'($urandom()));
    end
    repeat (6) begin
      send_request(toeq_pkg::REQ_PUT, $urandom(), toeq_pkg::DATA_W'($urandom()), $urandom());
    end
    repeat (QUEUE_DEPTH + 1) get_msg($urandom());
    drain_responses();
  endtask

  task automatic test_long_stall();
    time_base = last_release + 100;
    hold_requests++;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) begin
        put_msg(time_base + $urandom_range(0, 200), toeq_pkg::DATA_W'($urandom()));
      end else begin
        get_msg(time_base + $urandom_range(0, 300));
      end
    end
    drain_responses();
  endtask

  task automatic test_random_traffic(input logic rt, input int n_items, input int fill_target);
    logic [toeq_pkg::TIME_W-1:0] ofs;
    bit                          do_put;
    write_rt_mode(rt);
    time_base = last_release + 2000;
    for (int k = 0; k < n_items; k++) begin
      time_base += ($urandom_range(0, 50) == 0) ? $urandom_range(0, 1 << 18)
                                                 : $urandom_range(0, 40);
      case ($urandom_range(0, 19))
        0: put_msg($urandom_range(0, last_release), toeq_pkg::DATA_W'($urandom()));
        1: get_msg($urandom());
        default: begin
          do_put = (held_count < fill_target) ? ($urandom_range(0, 9) < 7)
                                              : ($urandom_range(0, 9) < 3);
          if (do_put) begin
            case ($urandom_range(0, 3))
              0: ofs = '0;
              1: ofs = $urandom_range(0, 15);
              default: ofs = $urandom_range(0, 4000);
            endcase
            put_msg(time_base + ofs, toeq_pkg::DATA_W'($urandom()));
          end else begin
            get_msg(time_base + $urandom_range(0, 3000) - 1500);
          end
        end
      endcase
    end
    drain_responses();
  endtask

  task automatic test_max_time();
    write_rt_mode(1'b0);
    while (held_count > 0) get_msg(32'hFFFF_FFFF);
    put_msg(32'hFFFF_FFFF, toeq_pkg::DATA_W'($urandom()));
    get_msg(32'hFFFF_FFFE);
    get_msg(32'hFFFF_FFFF);
    put_msg(32'd0, toeq_pkg::DATA_W'($urandom()));
    get_msg(32'hFFFF_FFFF);
    get_msg(32'd0);
    drain_responses();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = toeq_pkg::REQ_PUT;
    in_ch.msg_time = '0;
    in_ch.msg_data = '0;
    in_ch.now_time = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.rt_mode = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_ordering();
    test_rt_mode();
    test_full_queue();
    test_long_stall();
    test_random_traffic(1'b0, 450, 8);
    test_random_traffic(1'b1, 450, 24);
    test_random_traffic(1'b0, 400, QUEUE_DEPTH + 4);
    test_random_traffic(1'b1, 400, 3);
    test_max_time();
    drain_responses();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
